// ----- rtl/ntcb_pkg.sv -----
package ntcb_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS = 24;
    localparam int Y_W       = 31;
    localparam int K_W       = 5;
    localparam int LOG_W     = K_W + FRAC_BITS;
    localparam int LN_W      = 30;
    localparam int PROD_W    = 45;
    localparam int B100_W    = 20;
    localparam int BNUM_W    = 35;
    localparam int DEN_W     = 47;
    localparam int NUM_W     = 61;
    localparam int DIV_W     = 66;
    localparam int Q_W       = 18;
    localparam int BETA_W    = 13;
    localparam int TEMP_W    = 19;

    // Constants of the Beta equation
    localparam logic [LN_W-1:0]   LN2_Q30      = 30'd744261118;
    localparam logic [14:0]       T0_CENTI     = 15'd29815;
    localparam logic [6:0]        CENTI_SCALE  = 7'd100;
    localparam logic [21:0]       T0_X100_CC   = 22'd2981500;
    localparam logic [Q_W-1:0]    TK_MAX       = 18'd227315;
    localparam logic [TEMP_W-1:0] ZERO_C_CENTI = 19'd27315;
    localparam logic [TEMP_W-1:0] TEMP_MAX     = 19'd200000;
    localparam logic [TEMP_W-1:0] TEMP_MIN     = 19'h7954D;
    localparam logic [BETA_W-1:0] BETA_RESET   = 13'd3435;

    // Side information travelling with each transaction
    typedef struct packed {
        logic [1:0] ch;
        logic       zero;
        logic       ovf;
        logic       den_bad;
        logic       big;
    } side_t;

    // One squaring step of the log2 fraction: {fraction bit, new Q30 mantissa}
    function automatic logic [Y_W:0] sq_step(input logic [Y_W-1:0] y);
        logic [2*Y_W-1:0] p;
        logic [Y_W:0]     s;
        begin
            p = {{Y_W{1'b0}}, y} * {{Y_W{1'b0}}, y};
            s = p[2*Y_W-1:Y_W-1];
            sq_step = s[Y_W] ? {1'b1, s[Y_W:1]} : {1'b0, s[Y_W-1:0]};
        end
    endfunction

endpackage

// ----- rtl/ntc_thermistor_beta_temp.sv -----
// NTC thermistor temperature by the Beta equation, fully pipelined.
//
// Input channel (s_valid/s_ready): one converter code from a 10k/10k divider
// and its channel number. Result channel (m_valid/m_ready): channel copy,
// temperature in signed 0.01 C and a range flag for saturated results.
// Config channel (cfg_valid/cfg_ready): beta in kelvin; write it only while
// no transaction is in flight. cfg_ready is always high.
//
// Throughput: one transaction per cycle while the receiver does not stall. The
// stage count is set by the two log2 units (24 squaring stages each, one
// multiplier per stage) and the 18-stage restoring divider for the reciprocal.
//
// Reset clears every valid bit and the skid stage and loads beta 3435.
// When the receiver stalls, the last result is parked in a skid register and
// the whole pipeline holds until it is taken; s_ready drops for those cycles
// only and comes from a register.
module ntc_thermistor_beta_temp #(
    parameter int ADC_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [12:0]               cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_channel,
    input  logic [ADC_BITS-1:0]       s_adc_code,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_channel_out,
    output logic signed [18:0]        m_temp_centi_c,
    output logic                      m_range_flag
);

    localparam int YW   = ntcb_pkg::Y_W;
    localparam int KW   = ntcb_pkg::K_W;
    localparam int FW   = ntcb_pkg::FRAC_BITS;
    localparam int LW   = ntcb_pkg::LOG_W;
    localparam int NW   = ADC_BITS + 1;
    localparam int QW   = ntcb_pkg::Q_W;
    localparam int DW   = ntcb_pkg::DIV_W;
    localparam int ST_N = 2;
    localparam int ST_M = ST_N + FW;
    localparam int ST_L = ST_M + 1;
    localparam int ST_A = ST_L + 1;
    localparam int ST_B = ST_A + 1;
    localparam int ST_C = ST_B + 1;
    localparam int ST_D = ST_C + 1;
    localparam int ST_F = ST_D + QW + 1;
    localparam logic [NW-1:0] FULL = NW'(1) << ADC_BITS;

    // Leading-one normalisation into a Q30 mantissa
    function automatic logic [KW+YW-1:0] norm(input logic [NW-1:0] n);
        logic [KW-1:0] k;
        logic [YW-1:0] y;
        begin
            k = '0;
            for (int b = 0; b < NW; b++) begin
                if (n[b]) k = KW'(b);
            end
            y = YW'(n) << (KW'(YW - 1) - k);
            norm = {k, y};
        end
    endfunction

    logic                          en;
    logic [ntcb_pkg::BETA_W-1:0]   beta_reg;
    logic                          skid_full_reg;
    logic                          v_reg  [0:ST_F];
    ntcb_pkg::side_t               sd_reg [0:ST_F];
    ntcb_pkg::side_t               sd_next[1:ST_F];

    logic [ADC_BITS-1:0]           code_reg;
    logic [KW-1:0]                 ka_reg [1:ST_M-1];
    logic [KW-1:0]                 kb_reg [1:ST_M-1];
    logic [YW-1:0]                 ya_reg [1:ST_M-1];
    logic [YW-1:0]                 yb_reg [1:ST_M-1];
    logic [FW-1:0]                 fa_reg [1:ST_M-1];
    logic [FW-1:0]                 fb_reg [1:ST_M-1];

    logic                          neg_m_reg, neg_l_reg, neg_a_reg;
    logic [LW-1:0]                 mag_reg;
    logic [ntcb_pkg::LN_W-1:0]     lnmag_reg;
    logic [ntcb_pkg::PROD_W-1:0]   p1_reg;
    logic [ntcb_pkg::B100_W-1:0]   b100_reg;
    logic [ntcb_pkg::BNUM_W-1:0]   bn_a_reg, bn_b_reg;
    logic [ntcb_pkg::DEN_W-2:0]    ud_reg;
    logic [ntcb_pkg::NUM_W-1:0]    num_reg;
    logic [ntcb_pkg::DEN_W-1:0]    dsor_reg;
    logic [DW-1:0]                 r_reg  [ST_D:ST_F-1];
    logic [DW-1:0]                 d_reg  [ST_D:ST_F-1];
    logic [QW-1:0]                 q_reg  [ST_D:ST_F-1];

    logic [1:0]                    out_ch_reg, sk_ch_reg;
    logic [18:0]                   out_temp_reg, sk_temp_reg;
    logic                          out_flag_reg, sk_flag_reg;

    logic [KW+YW-1:0]              na, nb;
    logic [NW-1:0]                 den_code;
    logic [LW-1:0]                 la, lb;
    logic [ntcb_pkg::NUM_W-2:0]    ln_prod;
    logic signed [ntcb_pkg::DEN_W-1:0] den_base, den_p1, den_sum;
    logic [DW-1:0]                 big_lim;
    logic [18:0]                   temp_next;
    logic                          flag_next;

    // Pipeline advances unless the skid stage holds a stalled result
    assign en        = !skid_full_reg;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg <= ntcb_pkg::BETA_RESET;
        end else if (cfg_valid) begin
            beta_reg <= cfg_data;
        end
    end

    // Side information: update the fields decided at each stage
    always_comb begin
        for (int i = 1; i <= ST_F; i++) begin
            sd_next[i] = sd_reg[i-1];
        end
        sd_next[1].zero    = (code_reg == '0);
        sd_next[1].ovf     = ({1'b0, code_reg} >= FULL);
        sd_next[ST_B].den_bad = den_sum[ntcb_pkg::DEN_W-1] || (den_sum == '0);
        sd_next[ST_D].big  = big_lim <= DW'(num_reg);
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= ST_F; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= s_valid;
            for (int i = 1; i <= ST_F; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Side payload and input capture
    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= '{ch: s_channel, zero: 1'b0, ovf: 1'b0, den_bad: 1'b0, big: 1'b0};
            code_reg  <= s_adc_code;
            for (int i = 1; i <= ST_F; i++) begin
                sd_reg[i] <= sd_next[i];
            end
        end
    end

    // Normalise code and its complement
    assign den_code = FULL - {1'b0, code_reg};
    assign na       = norm({1'b0, code_reg});
    assign nb       = norm(den_code);

    always_ff @(posedge aclk) begin
        if (en) begin
            ka_reg[1] <= na[KW+YW-1:YW];
            ya_reg[1] <= na[YW-1:0];
            kb_reg[1] <= nb[KW+YW-1:YW];
            yb_reg[1] <= nb[YW-1:0];
            fa_reg[1] <= '0;
            fb_reg[1] <= '0;
        end
    end

    // Squaring stages: one fraction bit of each log2 per stage
    for (genvar s = 2; s < ST_M; s++) begin : g_sq
        logic [YW:0] sa, sb;
        assign sa = ntcb_pkg::sq_step(ya_reg[s-1]);
        assign sb = ntcb_pkg::sq_step(yb_reg[s-1]);
        always_ff @(posedge aclk) begin
            if (en) begin
                ka_reg[s] <= ka_reg[s-1];
                kb_reg[s] <= kb_reg[s-1];
                ya_reg[s] <= sa[YW-1:0];
                yb_reg[s] <= sb[YW-1:0];
                fa_reg[s] <= {fa_reg[s-1][FW-2:0], sa[YW]};
                fb_reg[s] <= {fb_reg[s-1][FW-2:0], sb[YW]};
            end
        end
    end

    // Log difference, ln scaling, products, equation numerator and denominator
    assign la       = {ka_reg[ST_M-1], fa_reg[ST_M-1]};
    assign lb       = {kb_reg[ST_M-1], fb_reg[ST_M-1]};
    assign ln_prod  = (ntcb_pkg::NUM_W-1)'(mag_reg) * (ntcb_pkg::NUM_W-1)'(ntcb_pkg::LN2_Q30)
                    + ((ntcb_pkg::NUM_W-1)'(1) << (ntcb_pkg::LN_W - 1));
    assign den_base = $signed({3'b000, b100_reg, {FW{1'b0}}});
    assign den_p1   = $signed({2'b00, p1_reg});
    assign den_sum  = neg_a_reg ? (den_base - den_p1) : (den_base + den_p1);
    assign big_lim  = DW'(dsor_reg) << QW;

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_m_reg <= la < lb;
            mag_reg   <= (la < lb) ? (lb - la) : (la - lb);
            neg_l_reg <= neg_m_reg;
            lnmag_reg <= ln_prod[ntcb_pkg::NUM_W-2:ntcb_pkg::LN_W];
            neg_a_reg <= neg_l_reg;
            p1_reg    <= ntcb_pkg::PROD_W'(lnmag_reg) * ntcb_pkg::PROD_W'(ntcb_pkg::T0_CENTI);
            b100_reg  <= ntcb_pkg::B100_W'(beta_reg) * ntcb_pkg::B100_W'(ntcb_pkg::CENTI_SCALE);
            bn_a_reg  <= ntcb_pkg::BNUM_W'(beta_reg) * ntcb_pkg::BNUM_W'(ntcb_pkg::T0_X100_CC);
            ud_reg    <= den_sum[ntcb_pkg::DEN_W-2:0];
            bn_b_reg  <= bn_a_reg;
            num_reg   <= (ntcb_pkg::NUM_W'(bn_b_reg) << (FW + 1)) + ntcb_pkg::NUM_W'(ud_reg);
            dsor_reg  <= {ud_reg, 1'b0};
            r_reg[ST_D] <= DW'(num_reg);
            d_reg[ST_D] <= DW'(dsor_reg);
            q_reg[ST_D] <= '0;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar t = 1; t <= QW; t++) begin : g_div
        logic [DW-1:0] sh;
        logic          ge;
        assign sh = d_reg[ST_D+t-1] << (QW - t);
        assign ge = r_reg[ST_D+t-1] >= sh;
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[ST_D+t] <= ge ? (r_reg[ST_D+t-1] - sh) : r_reg[ST_D+t-1];
                d_reg[ST_D+t] <= d_reg[ST_D+t-1];
                q_reg[ST_D+t] <= q_reg[ST_D+t-1] | (ge ? (QW'(1) << (QW - t)) : '0);
            end
        end
    end

    // Select special cases and convert to Celsius
    always_comb begin
        ntcb_pkg::side_t sd;
        sd = sd_reg[ST_F-1];
        if (sd.zero) begin
            temp_next = ntcb_pkg::TEMP_MIN;
            flag_next = 1'b0;
        end else if (sd.ovf) begin
            temp_next = ntcb_pkg::TEMP_MIN;
            flag_next = 1'b1;
        end else if (sd.den_bad || sd.big || (q_reg[ST_F-1] > ntcb_pkg::TK_MAX)) begin
            temp_next = ntcb_pkg::TEMP_MAX;
            flag_next = 1'b1;
        end else begin
            temp_next = {1'b0, q_reg[ST_F-1]} - ntcb_pkg::ZERO_C_CENTI;
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_ch_reg   <= sd_reg[ST_F-1].ch;
            out_temp_reg <= temp_next;
            out_flag_reg <= flag_next;
        end
    end

    // Skid stage: park the last result when the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_ready) skid_full_reg <= 1'b0;
        end else if (v_reg[ST_F] && !m_ready) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_full_reg) begin
            sk_ch_reg   <= out_ch_reg;
            sk_temp_reg <= out_temp_reg;
            sk_flag_reg <= out_flag_reg;
        end
    end

    assign m_valid        = skid_full_reg || v_reg[ST_F];
    assign m_channel_out  = skid_full_reg ? sk_ch_reg : out_ch_reg;
    assign m_temp_centi_c = $signed(skid_full_reg ? sk_temp_reg : out_temp_reg);
    assign m_range_flag   = skid_full_reg ? sk_flag_reg : out_flag_reg;

endmodule

// ----- rtl/ntcb_checker.sv -----
module ntcb_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [18:0] m_temp_centi_c,
    input logic               m_range_flag
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // Input back-pressure only while a result waits
    a_bp: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // Flagged results sit at a saturation limit
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_flag |->
            (m_temp_centi_c == 19'sd200000) || (m_temp_centi_c == -19'sd27315))
        else $error("flag raised off a limit");

    // Results stay within range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temp_centi_c >= -19'sd27315) && (m_temp_centi_c <= 19'sd200000))
        else $error("temperature out of range");

    // Nothing valid straight after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ntc_thermistor_beta_temp ntcb_checker u_ntcb_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_temp_centi_c (m_temp_centi_c),
    .m_range_flag   (m_range_flag)
);
